@@ src/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the melody tone sequencer: item structs,
// the command passed from front to back, operation and command codes.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Table and tone constants
    localparam int NOTE_SLOTS  = 256;
    localparam int SLOT_W      = $clog2(NOTE_SLOTS);
    localparam int PTR_W       = SLOT_W + 1;
    localparam int DIV_W       = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] TONE_BASE = 16'd60000;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Operation codes of an input item
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_PLAY   = 3'd2;
    localparam logic [2:0] OP_PAUSE  = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;

    // Command codes after classification
    localparam logic [2:0] K_NOP    = 3'd0;
    localparam logic [2:0] K_TICK   = 3'd1;
    localparam logic [2:0] K_LOAD   = 3'd2;
    localparam logic [2:0] K_PLAY   = 3'd3;
    localparam logic [2:0] K_PAUSE  = 3'd4;
    localparam logic [2:0] K_RESUME = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  note_slot;
        logic [15:0] note_freq_hz;
        logic [15:0] note_length_ms;
    } mts_in_t;

    typedef struct packed {
        logic        tone_on;
        logic [8:0]  current_note;
        logic [15:0] period_count;
        logic [14:0] compare_count;
        logic [31:0] time_played;
        logic        finished;
    } mts_out_t;

    // Classified command held in the queue
    typedef struct packed {
        logic [2:0]       kind;
        logic [SLOT_W-1:0] slot;
        logic [15:0]      freq;
        logic [15:0]      dur;
        logic [PTR_W-1:0] take_len;
    } mts_cmd_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } mts_qstat_t;

endpackage

@@ src/mts_div.sv @@
// ----------------------------------------------------------------------------
// mts_div
// Restoring divider: TONE_BASE divided by a 16-bit frequency, one quotient
// bit per cycle. Pulses done with the quotient after DIV_W steps.
// ----------------------------------------------------------------------------
module mts_div
    import mts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [DIV_W-1:0]     dvsr_reg, dvsr_next;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;
    logic                 ge;

    // One trial subtraction per step
    assign shifted = {rem_reg, quot_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, dvsr_reg};
    assign diff    = shifted - {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = TONE_BASE;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvsr_reg <= dvsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ src/mts_front.sv @@
// ----------------------------------------------------------------------------
// mts_front
// Accepts items, holds the melody length register and classifies each
// item into a command for the back end. Play commands carry the clamped
// length taken at that moment.
// ----------------------------------------------------------------------------
module mts_front
    import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  mts_in_t    cmd,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data,
    input  mts_qstat_t qstat,
    output logic       q_push,
    output mts_cmd_t   q_data
);

    logic [PTR_W-1:0] len_reg, len_next;
    logic [PTR_W-1:0] take_len;
    logic             slot_ok;

    // Configuration register
    assign cfg_ready = 1'b1;
    assign len_next  = (cfg_valid) ? cfg_data : len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // Length taken at play, clamped to the table size
    assign take_len = (len_reg > PTR_W'(NOTE_SLOTS)) ? PTR_W'(NOTE_SLOTS) : len_reg;
    assign slot_ok  = {1'b0, cmd.note_slot} < PTR_W'(NOTE_SLOTS);

    // Accept while the queue has room
    assign cmd_stall = qstat.full;
    assign q_push    = cmd_valid && !qstat.full;

    // Classify
    always_comb
    begin
        q_data.slot     = cmd.note_slot[SLOT_W-1:0];
        q_data.freq     = cmd.note_freq_hz;
        q_data.dur      = cmd.note_length_ms;
        q_data.take_len = take_len;
        unique case (cmd.operation)
            OP_TICK:   q_data.kind = K_TICK;
            OP_LOAD:   q_data.kind = slot_ok ? K_LOAD : K_NOP;
            OP_PLAY:   q_data.kind = K_PLAY;
            OP_PAUSE:  q_data.kind = K_PAUSE;
            OP_RESUME: q_data.kind = K_RESUME;
            default:   q_data.kind = K_NOP;
        endcase
    end

endmodule

@@ src/mts_queue.sv @@
// ----------------------------------------------------------------------------
// mts_queue
// Small command queue between front and back so each side stalls on its
// own.
// ----------------------------------------------------------------------------
module mts_queue
    import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  mts_cmd_t   push_data,
    input  logic       pop,
    output mts_cmd_t   head,
    output mts_qstat_t qstat
);

    mts_cmd_t          slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign qstat.full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign qstat.empty = cnt_reg == '0;
    assign head        = slots[rd_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_reg] <= push_data;
        end
    end

endmodule

@@ src/mts_back.sv @@
// ----------------------------------------------------------------------------
// mts_back
// Carries out queued commands: note table, play position, tick counting,
// tone computation through the divider, and the result register.
// ----------------------------------------------------------------------------
module mts_back
    import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mts_qstat_t qstat,
    input  mts_cmd_t   q_head,
    output logic       q_pop,
    output logic       res_valid,
    input  logic       res_stall,
    output mts_out_t   res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [PTR_W-1:0] taken_reg, taken_next;
    logic [31:0]      elapsed_reg, elapsed_next;
    logic [31:0]      prior_reg, prior_next;
    logic             paused_reg, paused_next;
    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [15:0]      period_reg, period_next;
    logic [14:0]      compare_reg, compare_next;
    logic [15:0]      cur_freq_reg, cur_freq_next;
    logic [15:0]      cur_len_reg, cur_len_next;
    logic             res_valid_reg, res_valid_next;
    mts_out_t         res_reg, res_next;

    // Note table: frequency in the upper half, duration in the lower
    logic [31:0]       note_mem [NOTE_SLOTS];
    logic [31:0]       mem_rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;

    logic             div_start;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [DIV_W-2:0] half_quot;

    logic [31:0]      elapsed_inc;
    logic             note_over;
    logic [32:0]      prior_sum;
    logic [31:0]      prior_sat;
    logic [PTR_W-1:0] ptr_inc;
    logic             last_note;
    logic [32:0]      time_sum;
    logic [31:0]      time_sat;

    // Divisor comes straight from the table word read for the new note
    mts_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (mem_rdata_reg[31:16]),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Tick arithmetic, saturating
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;
    assign note_over   = elapsed_inc > {16'd0, cur_len_reg};
    assign prior_sum   = {1'b0, prior_reg} + {17'd0, cur_len_reg};
    assign prior_sat   = prior_sum[32] ? '1 : prior_sum[31:0];
    assign ptr_inc     = ptr_reg + 1'b1;
    assign last_note   = ptr_inc >= taken_reg;
    assign time_sum    = {1'b0, prior_reg} + {1'b0, elapsed_reg};
    assign time_sat    = time_sum[32] ? '1 : time_sum[31:0];
    assign half_quot   = div_quot[DIV_W-1:1];

    // Command sequencing
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        taken_next     = taken_reg;
        elapsed_next   = elapsed_reg;
        prior_next     = prior_reg;
        paused_next    = paused_reg;
        active_next    = active_reg;
        done_next      = done_reg;
        period_next    = period_reg;
        compare_next   = compare_reg;
        cur_freq_next  = cur_freq_reg;
        cur_len_next   = cur_len_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        div_start      = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    q_pop      = 1'b1;
                    state_next = S_DONE;
                    unique case (q_head.kind)
                        K_TICK:
                        begin
                            if (active_reg && !paused_reg)
                            begin
                                if (note_over)
                                begin
                                    prior_next   = prior_sat;
                                    ptr_next     = ptr_inc;
                                    elapsed_next = '0;
                                    if (last_note)
                                    begin
                                        active_next  = 1'b0;
                                        done_next    = 1'b1;
                                        period_next  = '0;
                                        compare_next = '0;
                                    end
                                    else
                                    begin
                                        mem_re     = 1'b1;
                                        mem_raddr  = ptr_inc[SLOT_W-1:0];
                                        state_next = S_READ;
                                    end
                                end
                                else
                                begin
                                    elapsed_next = elapsed_inc;
                                end
                            end
                        end
                        K_LOAD:
                        begin
                            mem_we = 1'b1;
                            // a rewrite of the sounding note updates its frequency and length at once
                            if ({1'b0, q_head.slot} == ptr_reg)
                            begin
                                cur_freq_next = q_head.freq;
                                cur_len_next  = q_head.dur;
                            end
                        end
                        K_PLAY:
                        begin
                            taken_next   = q_head.take_len;
                            ptr_next     = '0;
                            prior_next   = '0;
                            paused_next  = 1'b0;
                            elapsed_next = '0;
                            if (q_head.take_len == '0)
                            begin
                                active_next  = 1'b0;
                                done_next    = 1'b1;
                                period_next  = '0;
                                compare_next = '0;
                            end
                            else
                            begin
                                active_next = 1'b1;
                                done_next   = 1'b0;
                                mem_re      = 1'b1;
                                state_next  = S_READ;
                            end
                        end
                        K_PAUSE:  paused_next = 1'b1;
                        K_RESUME: paused_next = 1'b0;
                        default:  ;
                    endcase
                end
            end
            S_READ:
            begin
                cur_freq_next = mem_rdata_reg[31:16];
                cur_len_next  = mem_rdata_reg[15:0];
                if (mem_rdata_reg[31:16] == '0)
                begin
                    period_next  = '0;
                    compare_next = '0;
                    state_next   = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    period_next  = (div_quot == '0) ? '0 : div_quot - 1'b1;
                    compare_next = (half_quot == '0) ? '0 : half_quot - 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next         = 1'b1;
                    res_next.tone_on       = active_reg && !paused_reg && (cur_freq_reg != '0);
                    res_next.current_note  = ptr_reg;
                    res_next.period_count  = period_reg;
                    res_next.compare_count = compare_reg;
                    res_next.time_played   = time_sat;
                    res_next.finished      = done_reg;
                    state_next             = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            taken_reg     <= '0;
            elapsed_reg   <= '0;
            prior_reg     <= '0;
            paused_reg    <= 1'b1;
            active_reg    <= 1'b0;
            done_reg      <= 1'b0;
            period_reg    <= '0;
            compare_reg   <= '0;
            cur_freq_reg  <= '0;
            cur_len_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            taken_reg     <= taken_next;
            elapsed_reg   <= elapsed_next;
            prior_reg     <= prior_next;
            paused_reg    <= paused_next;
            active_reg    <= active_next;
            done_reg      <= done_next;
            period_reg    <= period_next;
            compare_reg   <= compare_next;
            cur_freq_reg  <= cur_freq_next;
            cur_len_reg   <= cur_len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Note table port: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            note_mem[q_head.slot] <= {q_head.freq, q_head.dur};
        end
        if (mem_re)
        begin
            mem_rdata_reg <= note_mem[mem_raddr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Checks
    a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (ptr_reg < taken_reg))
        else $error("play pointer beyond taken length while active");

    a_active_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(active_reg && done_reg))
        else $error("active and finished at once");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("queue popped while a command is in progress");

    a_div_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_DIV))
        else $error("divider started outside the tone load sequence");

    a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(mem_re))
        else $error("table data used without a read issued");

endmodule

@@ src/melody_tone_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// melody_tone_sequencer_unit
// Melody player: note table, tick-driven note stepping and buzzer tone
// values, one result item for every command item.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result item. The front end takes an
// item in the cycle it is offered whenever its two-entry queue has room, so
// up to two items can be buffered while the back end works or the result
// waits. Load, pause, resume, unknown items, empty plays and ticks that
// start no new note go through dequeue and result only. Other plays and
// ticks also read the note table and, for a nonzero frequency, divide 60000
// by it in a 16-step restoring division. The user writes melody_length via
// the cfg port (always ready) only while no item is in flight; the block
// does not enforce this. It is sampled at each play.
module melody_tone_sequencer_unit
    import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  mts_in_t    cmd,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data,
    output logic       res_valid,
    input  logic       res_stall,
    output mts_out_t   res
);

    mts_qstat_t qstat;
    logic       q_push;
    logic       q_pop;
    mts_cmd_t   q_data;
    mts_cmd_t   q_head;

    mts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    mts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .qstat     (qstat)
    );

    mts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
